@@ hw/rtl/dotf_pkg.sv @@
package dotf_pkg;

  localparam int unsigned MaxAreaBytes = 1024;

  localparam logic [7:0] EndCode = 8'hff;
  localparam logic [7:0] PadCode = 8'h00;

  typedef enum logic [1:0] {
    PH_DONE = 2'd0,
    PH_CODE = 2'd1,
    PH_LEN  = 2'd2,
    PH_SKIP = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_END     = 2'd1,
    ST_OVERRUN = 2'd2,
    ST_EXHAUST = 2'd3
  } status_e;

  typedef struct packed {
    logic [9:0] option_offset;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic [10:0] area_length;
    logic [7:0]  option_byte;
  } item_t;

endpackage

@@ hw/rtl/dotf_scan.sv @@
module dotf_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  dotf_pkg::item_t   item_i,
  input  logic              first_byte_i,
  input  logic [7:0]        target_code_i,
  output logic              res_valid_o,
  output dotf_pkg::result_t res_o
);

  dotf_pkg::phase_e phase_q, phase_d;
  logic [10:0] pos_q, pos_d;
  logic [10:0] size_q, size_d;
  logic [9:0]  start_q, start_d;
  logic [7:0]  skip_q, skip_d;
  logic        match_q, match_d;

  // State as seen after an area restart, if any
  dotf_pkg::phase_e phase_e0;
  logic [10:0] pos_e, size_e, len_clamp;
  logic [9:0]  start_e;
  logic [7:0]  skip_e, skip_dec, b;
  logic        match_e;
  logic [11:0] nxt, rec_end;
  logic        at_end;

  assign b = item_i.option_byte;
  assign len_clamp = (item_i.area_length > 11'(dotf_pkg::MaxAreaBytes)) ?
                     11'(dotf_pkg::MaxAreaBytes) : item_i.area_length;

  always_comb begin
    if (first_byte_i) begin
      phase_e0 = dotf_pkg::PH_CODE;
      pos_e    = '0;
      size_e   = len_clamp;
      start_e  = '0;
      skip_e   = '0;
      match_e  = 1'b0;
    end else begin
      phase_e0 = phase_q;
      pos_e    = pos_q;
      size_e   = size_q;
      start_e  = start_q;
      skip_e   = skip_q;
      match_e  = match_q;
    end
  end

  assign nxt      = {1'b0, pos_e} + 12'd1;
  assign rec_end  = nxt + {4'd0, b};
  assign at_end   = nxt >= {1'b0, size_e};
  assign skip_dec = skip_e - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    size_d      = size_q;
    start_d     = start_q;
    skip_d      = skip_q;
    match_d     = match_q;
    res_valid_o = 1'b0;
    res_o.status        = dotf_pkg::ST_FOUND;
    res_o.option_offset = '0;
    if (item_valid_i) begin
      phase_d = phase_e0;
      pos_d   = pos_e;
      size_d  = size_e;
      start_d = start_e;
      skip_d  = skip_e;
      match_d = match_e;
      if (first_byte_i && (size_e == '0)) begin
        res_valid_o  = 1'b1;
        res_o.status = dotf_pkg::ST_EXHAUST;
        phase_d      = dotf_pkg::PH_DONE;
      end else if (phase_e0 != dotf_pkg::PH_DONE) begin
        pos_d = nxt[10:0];
        case (phase_e0)
          dotf_pkg::PH_CODE: begin
            if (b == dotf_pkg::EndCode) begin
              res_valid_o = 1'b1;
              phase_d     = dotf_pkg::PH_DONE;
              if (target_code_i == dotf_pkg::EndCode) begin
                res_o.option_offset = pos_e[9:0];
              end else begin
                res_o.status = dotf_pkg::ST_END;
              end
            end else if (b == dotf_pkg::PadCode) begin
              if (target_code_i == dotf_pkg::PadCode) begin
                res_valid_o         = 1'b1;
                res_o.option_offset = pos_e[9:0];
                phase_d             = dotf_pkg::PH_DONE;
              end else if (at_end) begin
                res_valid_o  = 1'b1;
                res_o.status = dotf_pkg::ST_EXHAUST;
                phase_d      = dotf_pkg::PH_DONE;
              end
            end else if (at_end) begin
              res_valid_o  = 1'b1;
              res_o.status = dotf_pkg::ST_OVERRUN;
              phase_d      = dotf_pkg::PH_DONE;
            end else begin
              start_d = pos_e[9:0];
              match_d = (b == target_code_i);
              phase_d = dotf_pkg::PH_LEN;
            end
          end
          dotf_pkg::PH_LEN: begin
            if (rec_end > {1'b0, size_e}) begin
              res_valid_o  = 1'b1;
              res_o.status = dotf_pkg::ST_OVERRUN;
              phase_d      = dotf_pkg::PH_DONE;
            end else if (match_e) begin
              res_valid_o         = 1'b1;
              res_o.option_offset = start_e;
              phase_d             = dotf_pkg::PH_DONE;
            end else if (b == 8'd0) begin
              if (at_end) begin
                res_valid_o  = 1'b1;
                res_o.status = dotf_pkg::ST_EXHAUST;
                phase_d      = dotf_pkg::PH_DONE;
              end else begin
                phase_d = dotf_pkg::PH_CODE;
              end
            end else begin
              skip_d  = b;
              phase_d = dotf_pkg::PH_SKIP;
            end
          end
          dotf_pkg::PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == 8'd0) begin
              if (at_end) begin
                res_valid_o  = 1'b1;
                res_o.status = dotf_pkg::ST_EXHAUST;
                phase_d      = dotf_pkg::PH_DONE;
              end else begin
                phase_d = dotf_pkg::PH_CODE;
              end
            end
          end
          default: begin
            phase_d = dotf_pkg::PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dotf_pkg::PH_DONE;
      pos_q   <= '0;
      size_q  <= '0;
      start_q <= '0;
      skip_q  <= '0;
      match_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      size_q  <= size_d;
      start_q <= start_d;
      skip_q  <= skip_d;
      match_q <= match_d;
    end
  end

endmodule

@@ hw/rtl/dotf_out_buf.sv @@
module dotf_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dotf_pkg::result_t push_data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output dotf_pkg::result_t data_o
);

  logic              out_valid_q, skid_valid_q;
  dotf_pkg::result_t out_q, skid_q;
  logic              load_out;

  assign ready_o  = !skid_valid_q;
  assign valid_o  = out_valid_q;
  assign data_o   = out_q;
  // Output slot frees up when empty or being taken
  assign load_out = !out_valid_q || pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_out) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/dhcp_option_tlv_finder.sv @@
// DHCP option TLV finder.
// Slave stream: one byte of the options area (after the magic cookie) per
// transfer. tuser marks the first byte of an area; on that transfer the area
// length in tdata is sampled (clamped to 1024). Master stream: at most one
// result per area: status (found, end option first, record overrun, area
// exhausted) and the found option's code byte position.
// The searched code is written on target_code_we_i/target_code_i while idle.
// Throughput: one byte per cycle while s_tready is high. Each accepted byte
// updates the scan state in the same cycle and a result is registered at
// that edge, into the result register or, if that is held, the skid one.
// A result register plus a skid register sit on the master side: s_tready
// drops only when both are full, i.e. after the receiver has stalled with
// two results pending. Bytes after a decision and before the next first
// byte are absorbed without output.
// Reset: scan idles (bytes ignored until a first byte), target code 255,
// output buffer empty.
module dhcp_option_tlv_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [7:0] option_byte, [18:8] area_length, rest zero
  input  logic        s_axis_tuser_i,  // [0] first_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [1:0] status, [11:2] option_offset, rest zero
  input  logic        target_code_we_i,
  input  logic [7:0]  target_code_i
);

  logic [7:0]        target_code_q;
  logic              accept;
  logic              res_valid;
  dotf_pkg::result_t res;
  dotf_pkg::result_t out_res;
  dotf_pkg::item_t   item;

  assign item   = dotf_pkg::item_t'(s_axis_tdata_i[18:0]);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_code_q <= dotf_pkg::EndCode;
    end else if (target_code_we_i) begin
      target_code_q <= target_code_i;
    end
  end

  // Scan state advances on every accepted byte
  dotf_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (accept),
    .item_i       (item),
    .first_byte_i (s_axis_tuser_i),
    .target_code_i(target_code_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Hold results while the receiver stalls
  dotf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tdata_o = {4'd0, out_res};

endmodule
